// ----- rtl/circular_deque_assert.svh -----
// Assertion macros for the circular deque.
// Used by the top level only; needs nothing else.
`ifndef CIRCULAR_DEQUE_ASSERT_SVH
`define CIRCULAR_DEQUE_ASSERT_SVH

// Same-cycle implication, quiet during reset.
`define CDQ_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("circular_deque: check failed");

// Next-cycle implication, quiet during reset.
`define CDQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("circular_deque: check failed");

`endif

// ----- rtl/cdq_pkg.sv -----
// Shared types and constants for the circular deque.
// No dependencies.
`default_nettype none

package cdq_pkg;

  localparam int DEPTH = 8;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int FUNC_W = 3;
  localparam int STATUS_W = 2;
  localparam int OCC_W = 4;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_REAR  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_REAR   = 3'd3,
    FN_LIST       = 3'd4
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_LIST
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_PREV,
    CELL_FROM_NEXT
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic signed [WORD_W-1:0]  load_word;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/cdq_if.sv -----
// Valid/ready channels for the circular deque: request and result words.
// Depends on cdq_pkg.
`default_nettype none

interface cdq_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [cdq_pkg::FUNC_W-1:0]           func;
  logic signed [cdq_pkg::WORD_W-1:0]    data_in;

  modport source (output valid, output func, output data_in, input ready);
  modport sink (input valid, input func, input data_in, output ready);
endinterface

interface cdq_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [cdq_pkg::STATUS_W-1:0]         status;
  logic signed [cdq_pkg::WORD_W-1:0]    data_out;
  logic [cdq_pkg::OCC_W-1:0]            occupancy;
  logic                                 last;

  modport source (output valid, output status, output data_out, output occupancy,
                  output last, input ready);
  modport sink (input valid, input status, input data_out, input occupancy,
                input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/cdq_cell.sv -----
// One storage cell of the deque chain: hold, load, or take a neighbor's word.
// Depends on cdq_pkg.
`default_nettype none

module cdq_cell (
  input  wire logic                              clk,
  input  wire cdq_pkg::cell_ctrl_t               ctrl,
  input  wire logic signed [cdq_pkg::WORD_W-1:0] prev_word,
  input  wire logic signed [cdq_pkg::WORD_W-1:0] next_word,
  output logic signed [cdq_pkg::WORD_W-1:0]      word
);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      cdq_pkg::CELL_LOAD:      word <= ctrl.load_word;
      cdq_pkg::CELL_FROM_PREV: word <= prev_word;
      cdq_pkg::CELL_FROM_NEXT: word <= next_word;
      default:                 word <= word;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/circular_deque.sv -----
// Double-ended queue of signed 32-bit words held front to rear in a row of
// cells, cell 0 at the front. A new request is taken every cycle while the
// result register can drain. A listing is taken first; then, for each
// element, the chain rotates by one cell toward the front and the front word
// goes out, each step waiting until the result register can drain. Requests
// are held off during those steps, and after them the order is as before.
// A full push or an empty pop gives one refusal word and changes nothing.
// Codes 5 to 7 are taken and give no result. Depends on cdq_pkg, cdq_if,
// cdq_cell and circular_deque_assert.svh.
`default_nettype none

`include "circular_deque_assert.svh"

module circular_deque (
  input  wire logic clk,
  input  wire logic rst,
  cdq_in_if.sink    in_ch,
  cdq_out_if.source out_ch
);

  localparam int DEPTH = cdq_pkg::DEPTH;
  localparam int IDX_W = cdq_pkg::IDX_W;
  localparam int CNT_W = cdq_pkg::CNT_W;
  localparam int WORD_W = cdq_pkg::WORD_W;

  cdq_pkg::state_t            state;
  cdq_pkg::state_t            state_next;
  logic [CNT_W-1:0]           count;
  logic [CNT_W-1:0]           count_next;
  logic [CNT_W-1:0]           remain;
  logic [CNT_W-1:0]           remain_next;

  logic                       out_valid;
  logic                       out_valid_next;
  cdq_pkg::status_t           out_status;
  cdq_pkg::status_t           out_status_next;
  logic signed [WORD_W-1:0]   out_data;
  logic signed [WORD_W-1:0]   out_data_next;
  logic                       out_last;
  logic                       out_last_next;

  logic                       out_free;
  logic                       in_fire;
  logic                       list_step;
  logic                       full;
  logic                       empty;
  logic [CNT_W-1:0]           cnt_dec;
  logic [CNT_W-1:0]           cnt_inc;
  logic [IDX_W-1:0]           rear_idx;
  logic [IDX_W-1:0]           tail_idx;

  logic signed [WORD_W-1:0]   words [DEPTH];
  cdq_pkg::cell_ctrl_t        ctrls [DEPTH];

  assign out_free = !out_valid || out_ch.ready;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign cnt_dec  = count - CNT_W'(1);
  assign cnt_inc  = count + CNT_W'(1);
  assign rear_idx = cnt_dec[IDX_W-1:0];
  assign tail_idx = count[IDX_W-1:0];

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      cdq_pkg::S_IDLE: begin
        if (in_fire && in_ch.func == cdq_pkg::FN_LIST && !empty) begin
          state_next = cdq_pkg::S_LIST;
        end
      end
      cdq_pkg::S_LIST: begin
        if (out_free && remain == CNT_W'(1)) begin
          state_next = cdq_pkg::S_IDLE;
        end
      end
      default: state_next = cdq_pkg::S_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_ch.ready = 1'b0;
    list_step   = 1'b0;
    unique case (state)
      cdq_pkg::S_IDLE: in_ch.ready = out_free;
      cdq_pkg::S_LIST: list_step   = out_free;
      default: begin
        in_ch.ready = 1'b0;
        list_step   = 1'b0;
      end
    endcase
  end

  // Cell controls, count and result word
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctrls[i].op        = cdq_pkg::CELL_HOLD;
      ctrls[i].load_word = in_ch.data_in;
    end
    count_next      = count;
    remain_next     = remain;
    out_valid_next  = out_valid && !out_ch.ready;
    out_status_next = out_status;
    out_data_next   = out_data;
    out_last_next   = out_last;

    if (in_fire) begin
      out_status_next = cdq_pkg::STAT_DONE;
      out_data_next   = '0;
      out_last_next   = 1'b1;
      case (in_ch.func)
        cdq_pkg::FN_PUSH_FRONT: begin
          out_valid_next = 1'b1;
          if (full) begin
            out_status_next = cdq_pkg::STAT_FULL;
          end else begin
            for (int i = 1; i < DEPTH; i++) begin
              ctrls[i].op = cdq_pkg::CELL_FROM_PREV;
            end
            ctrls[0].op = cdq_pkg::CELL_LOAD;
            count_next  = cnt_inc;
          end
        end
        cdq_pkg::FN_PUSH_REAR: begin
          out_valid_next = 1'b1;
          if (full) begin
            out_status_next = cdq_pkg::STAT_FULL;
          end else begin
            ctrls[tail_idx].op = cdq_pkg::CELL_LOAD;
            count_next         = cnt_inc;
          end
        end
        cdq_pkg::FN_POP_FRONT: begin
          out_valid_next = 1'b1;
          if (empty) begin
            out_status_next = cdq_pkg::STAT_EMPTY;
          end else begin
            for (int i = 0; i < DEPTH; i++) begin
              ctrls[i].op = cdq_pkg::CELL_FROM_NEXT;
            end
            out_data_next = words[0];
            count_next    = cnt_dec;
          end
        end
        cdq_pkg::FN_POP_REAR: begin
          out_valid_next = 1'b1;
          if (empty) begin
            out_status_next = cdq_pkg::STAT_EMPTY;
          end else begin
            out_data_next = words[rear_idx];
            count_next    = cnt_dec;
          end
        end
        cdq_pkg::FN_LIST: begin
          if (empty) begin
            out_valid_next  = 1'b1;
            out_status_next = cdq_pkg::STAT_EMPTY;
          end else begin
            remain_next = count;
          end
        end
        default: begin
        end
      endcase
    end else if (list_step) begin
      // rotate toward the front, wrap the front word to the rear
      for (int i = 0; i < DEPTH; i++) begin
        if (CNT_W'(i) < cnt_dec) begin
          ctrls[i].op = cdq_pkg::CELL_FROM_NEXT;
        end
      end
      ctrls[rear_idx].op        = cdq_pkg::CELL_LOAD;
      ctrls[rear_idx].load_word = words[0];
      out_valid_next  = 1'b1;
      out_status_next = cdq_pkg::STAT_DONE;
      out_data_next   = words[0];
      out_last_next   = (remain == CNT_W'(1));
      remain_next     = remain - CNT_W'(1);
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [WORD_W-1:0] prev_w;
    logic signed [WORD_W-1:0] next_w;
    if (g == 0) begin : g_first
      assign prev_w = words[g];
    end else begin : g_mid_prev
      assign prev_w = words[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign next_w = words[g];
    end else begin : g_mid_next
      assign next_w = words[g+1];
    end
    cdq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrls[g]),
      .prev_word (prev_w),
      .next_word (next_w),
      .word      (words[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cdq_pkg::S_IDLE;
      count     <= '0;
      remain    <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      remain    <= remain_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_status <= out_status_next;
    out_data   <= out_data_next;
    out_last   <= out_last_next;
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.status    = out_status;
  assign out_ch.data_out  = out_data;
  assign out_ch.occupancy = cdq_pkg::OCC_W'(count);
  assign out_ch.last      = out_last;

  `CDQ_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(DEPTH))
  `CDQ_ASSERT_NOW(a_list_blocks_input, clk, rst, state == cdq_pkg::S_LIST, !in_ch.ready)
  `CDQ_ASSERT_NEXT(a_list_streams, clk, rst,
    out_ch.valid && out_ch.ready && !out_ch.last, out_ch.valid)
  `CDQ_ASSERT_NEXT(a_pop_shrinks, clk, rst,
    in_fire && !empty && (in_ch.func == cdq_pkg::FN_POP_FRONT ||
    in_ch.func == cdq_pkg::FN_POP_REAR), count == $past(cnt_dec))

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking bench for circular_deque: random and directed requests on the request
// channel, every result word checked in order against a deque predictor.
// Depends on cdq_pkg, cdq_if and the circular_deque RTL.
`default_nettype none

module testbench;

  localparam logic [cdq_pkg::FUNC_W-1:0] FN_SPARE_A = 3'd5;
  localparam logic [cdq_pkg::FUNC_W-1:0] FN_SPARE_B = 3'd6;
  localparam logic [cdq_pkg::FUNC_W-1:0] FN_SPARE_C = 3'd7;
  localparam int RANDOM_ITEMS = 320;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    cdq_pkg::status_t                  status;
    logic signed [cdq_pkg::WORD_W-1:0] word;
    logic [cdq_pkg::OCC_W-1:0]         occupancy;
    logic                              last;
  } deque_result_t;

  class deque_scoreboard;
    logic signed [cdq_pkg::WORD_W-1:0] store [cdq_pkg::DEPTH];
    int                                front_idx;
    int                                rear_idx;
    int                                count;
    deque_result_t                     expected_q [$];
    int                                errors;

    function new();
      front_idx = 0;
      rear_idx = 0;
      count = 0;
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void add(cdq_pkg::status_t st, logic signed [cdq_pkg::WORD_W-1:0] w, logic fin);
      deque_result_t r;
      r.status = st;
      r.word = w;
      r.occupancy = count[cdq_pkg::OCC_W-1:0];
      r.last = fin;
      expected_q.push_back(r);
    endfunction

    function void note_request(logic [cdq_pkg::FUNC_W-1:0] code,
                               logic signed [cdq_pkg::WORD_W-1:0] w);
      logic signed [cdq_pkg::WORD_W-1:0] taken;
      case (code)
        cdq_pkg::FN_PUSH_FRONT, cdq_pkg::FN_PUSH_REAR: begin
          if (count >= cdq_pkg::DEPTH) begin
            add(cdq_pkg::STAT_FULL, '0, 1'b1);
          end else begin
            if (count == 0) begin
              front_idx = 0;
              rear_idx = 0;
              store[0] = w;
            end else if (code == cdq_pkg::FN_PUSH_FRONT) begin
              front_idx = (front_idx + cdq_pkg::DEPTH - 1) % cdq_pkg::DEPTH;
              store[front_idx] = w;
            end else begin
              rear_idx = (rear_idx + 1) % cdq_pkg::DEPTH;
              store[rear_idx] = w;
            end
            count++;
            add(cdq_pkg::STAT_DONE, '0, 1'b1);
          end
        end
        cdq_pkg::FN_POP_FRONT, cdq_pkg::FN_POP_REAR: begin
          if (count == 0) begin
            add(cdq_pkg::STAT_EMPTY, '0, 1'b1);
          end else begin
            if (code == cdq_pkg::FN_POP_FRONT) begin
              taken = store[front_idx];
              front_idx = (front_idx + 1) % cdq_pkg::DEPTH;
            end else begin
              taken = store[rear_idx];
              rear_idx = (rear_idx + cdq_pkg::DEPTH - 1) % cdq_pkg::DEPTH;
            end
            count--;
            if (count == 0) begin
              front_idx = 0;
              rear_idx = 0;
            end
            add(cdq_pkg::STAT_DONE, taken, 1'b1);
          end
        end
        cdq_pkg::FN_LIST: begin
          if (count == 0) begin
            add(cdq_pkg::STAT_EMPTY, '0, 1'b1);
          end else begin
            for (int i = 0; i < count; i++)
              add(cdq_pkg::STAT_DONE, store[(front_idx + i) % cdq_pkg::DEPTH], i == count - 1);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [cdq_pkg::STATUS_W-1:0] st,
                               logic signed [cdq_pkg::WORD_W-1:0] w,
                               logic [cdq_pkg::OCC_W-1:0] occ, logic fin);
      deque_result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result word: status %0d data_out %0d occupancy %0d last %0b",
               st, w, occ, fin);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (st !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, st);
        errors++;
      end
      if (w !== want.word) begin
        $error("data_out: expected %0d, actual %0d", want.word, w);
        errors++;
      end
      if (occ !== want.occupancy) begin
        $error("occupancy: expected %0d, actual %0d", want.occupancy, occ);
        errors++;
      end
      if (fin !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, fin);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  bit   calm = 1'b0;
  bit   hold_off_req = 1'b0;

  deque_scoreboard sb = new();

  cdq_in_if  in_ch ();
  cdq_out_if out_ch ();

  circular_deque i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_request(in_ch.func, in_ch.data_in);
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.status, out_ch.data_out, out_ch.occupancy, out_ch.last);
    end
  end

  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  task automatic send_word(input logic [cdq_pkg::FUNC_W-1:0] code,
                           input logic signed [cdq_pkg::WORD_W-1:0] w);
    in_ch.valid <= 1'b1;
    in_ch.func <= code;
    in_ch.data_in <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic idle_gap(input int cycles);
    in_ch.valid <= 1'b0;
    in_ch.func <= cdq_pkg::FUNC_W'($urandom);
    in_ch.data_in <= cdq_pkg::WORD_W'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  function automatic logic signed [cdq_pkg::WORD_W-1:0] random_word();
    case ($urandom_range(0, 7))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // bias: 0 leans to pushes, 1 leans to pops, 2 leans slightly to pops
  function automatic logic [cdq_pkg::FUNC_W-1:0] pick_func(input int bias);
    int roll;
    int push_pct;
    roll = $urandom_range(0, 99);
    push_pct = (bias == 0) ? 65 : (bias == 1) ? 25 : 45;
    if (roll < 3)
      return FN_SPARE_A + cdq_pkg::FUNC_W'($urandom_range(0, 2));
    if (roll < 13)
      return cdq_pkg::FN_LIST;
    if ($urandom_range(0, 99) < push_pct)
      return $urandom_range(0, 1) ? cdq_pkg::FN_PUSH_FRONT : cdq_pkg::FN_PUSH_REAR;
    return $urandom_range(0, 1) ? cdq_pkg::FN_POP_FRONT : cdq_pkg::FN_POP_REAR;
  endfunction

  initial begin
    int                         sent;
    int                         bias;
    bit                         held;
    bit                         paused;
    logic [cdq_pkg::FUNC_W-1:0] code;

    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.func = cdq_pkg::FN_LIST;
    in_ch.data_in = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_word(cdq_pkg::FN_LIST, '0);
    send_word(cdq_pkg::FN_POP_FRONT, '0);
    send_word(cdq_pkg::FN_POP_REAR, -32'sd1);
    send_word(cdq_pkg::FN_PUSH_FRONT, 32'sh7fff_ffff);
    send_word(cdq_pkg::FN_POP_REAR, '0);
    send_word(cdq_pkg::FN_PUSH_REAR, 32'sh8000_0000);
    send_word(cdq_pkg::FN_PUSH_FRONT, '0);
    send_word(cdq_pkg::FN_PUSH_REAR, -32'sd1);
    send_word(cdq_pkg::FN_PUSH_FRONT, 32'sd1);
    send_word(cdq_pkg::FN_PUSH_REAR, 32'sh5555_5555);
    send_word(cdq_pkg::FN_PUSH_FRONT, 32'shaaaa_aaaa);
    send_word(cdq_pkg::FN_PUSH_REAR, 32'sh7fff_ffff);
    send_word(cdq_pkg::FN_PUSH_FRONT, 32'sh8000_0000);
    send_word(cdq_pkg::FN_PUSH_REAR, 32'sd123);
    send_word(cdq_pkg::FN_PUSH_FRONT, 32'sd456);
    send_word(cdq_pkg::FN_LIST, '0);
    send_word(FN_SPARE_A, 32'sd7);
    send_word(FN_SPARE_B, -32'sd1);
    send_word(FN_SPARE_C, 32'sh8000_0000);
    send_word(cdq_pkg::FN_POP_FRONT, '0);
    send_word(cdq_pkg::FN_POP_REAR, '0);
    send_word(cdq_pkg::FN_LIST, '0);
    for (int i = 0; i < cdq_pkg::DEPTH - 2; i++)
      send_word(i[0] ? cdq_pkg::FN_POP_REAR : cdq_pkg::FN_POP_FRONT, '0);
    send_word(cdq_pkg::FN_LIST, '0);

    // hold the sender until every directed result is back
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);

    sent = 0;
    bias = 2;
    held = 1'b0;
    paused = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      if (sent % 40 == 0)
        bias = $urandom_range(0, 2);
      if (sent == 150 && !held) begin
        held = 1'b1;
        hold_off_req = 1'b1;
      end
      if (sent == 250 && !paused) begin
        paused = 1'b1;
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end
      if (sent >= RANDOM_ITEMS - 60)
        calm = 1'b1;
      if (!calm && $urandom_range(0, 4) == 0)
        idle_gap($urandom_range(1, 16));
      code = pick_func(bias);
      send_word(code, random_word());
      if (code <= cdq_pkg::FN_LIST)
        sent++;
    end
    in_ch.valid <= 1'b0;

    do @(posedge clk); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire

// ----- circular_deque.f -----
+incdir+rtl
rtl/cdq_pkg.sv
rtl/cdq_if.sv
rtl/cdq_cell.sv
rtl/circular_deque.sv
dv/testbench.sv
